### hw/rtl/matrix_vector_multiply_core_macros.svh
// ----------------------------------------------------------------------------
// matrix vector multiply core assertion macros
// shared assertion forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_VECTOR_MULTIPLY_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define MVM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define MVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// shared constants, codes and types of the matrix vector multiply core
// ----------------------------------------------------------------------------
`default_nettype none

package mvm_pkg;

  // store geometry
  localparam int MAX_DIM = 32;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);

  // field widths
  localparam int DATA_W  = 32;
  localparam int ACC_W   = 64;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int ACT_W   = 2;
  localparam int CFG_W   = 6;
  localparam int CFG_A_W = 2;

  // request actions
  localparam logic [ACT_W-1:0] ACT_MATRIX  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_VECTOR  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SYMMETRIC = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // control that travels alongside each multiply-accumulate
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_col;
    logic             last_row;
    logic [ROW_W-1:0] row;
  } mac_tag_t;

endpackage

`default_nettype wire

### hw/rtl/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/mvm_cell.sv
// ----------------------------------------------------------------------------
// mvm_cell
// one vector element of the rotating vector ring
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_cell (
  input  wire logic                       clk,
  input  wire logic                       load,
  input  wire logic [mvm_pkg::DATA_W-1:0] load_value,
  input  wire logic                       shift,
  input  wire logic [mvm_pkg::DATA_W-1:0] shift_in,
  output logic      [mvm_pkg::DATA_W-1:0] value
);

  // load and shift never coincide: loads happen only while idle
  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_value;
    end else if (shift) begin
      value <= shift_in;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac
// multiply, round to q16.16, accumulate and saturate one row at a time
// ----------------------------------------------------------------------------
`default_nettype none

module mvm_mac (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mvm_pkg::mac_tag_t                 tag_in,
  input  wire logic signed [mvm_pkg::DATA_W-1:0] mat_value,
  input  wire logic signed [mvm_pkg::DATA_W-1:0] vec_value,
  output logic                                   result_valid,
  output logic        [mvm_pkg::ROW_W-1:0]       result_row,
  output logic signed [mvm_pkg::DATA_W-1:0]      result_value,
  output logic                                   saturated,
  output logic                                   last
);

  localparam int SAT_W = mvm_pkg::ACC_W - mvm_pkg::DATA_W + 1;

  mvm_pkg::mac_tag_t                    tag_mul;
  mvm_pkg::mac_tag_t                    tag_acc;
  logic signed [mvm_pkg::ACC_W-1:0]     prod;
  logic signed [mvm_pkg::ACC_W-1:0]     rnd;
  logic signed [mvm_pkg::ACC_W-1:0]     acc;
  logic        [SAT_W-1:0]              acc_top;
  logic                                 acc_over;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_mul <= '0;
    end else begin
      tag_mul <= tag_in;
    end
    prod <= mvm_pkg::ACC_W'(mat_value) * mvm_pkg::ACC_W'(vec_value);
  end

  // add half an lsb, then floor shift
  assign rnd = (prod + mvm_pkg::ACC_W'(32768)) >>> 16;

  // accumulate stage, the row sum
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_acc <= '0;
      acc     <= '0;
    end else begin
      tag_acc <= tag_mul;
      if (tag_mul.valid) begin
        acc <= tag_mul.first ? rnd : acc + rnd;
      end
    end
  end

  // out of range when the upper bits are not all copies of the sign
  assign acc_top  = acc[mvm_pkg::ACC_W-1:mvm_pkg::DATA_W-1];
  assign acc_over = !((&acc_top) || !(|acc_top));

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tag_acc.valid && tag_acc.last_col;
    end
    result_row <= tag_acc.row;
    saturated  <= acc_over;
    last       <= tag_acc.last_row;
    if (acc_over) begin
      result_value <= acc[mvm_pkg::ACC_W-1] ? {1'b1, {(mvm_pkg::DATA_W-1){1'b0}}}
                                            : {1'b0, {(mvm_pkg::DATA_W-1){1'b1}}};
    end else begin
      result_value <= acc[mvm_pkg::DATA_W-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/matrix_vector_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// matrix and vector stores with a row-by-row q16.16 dot product engine
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------
//  request   start && !busy            action, row_index, col_index,
//                                      element_value
//  config    cfg_write                 cfg_index, cfg_data
//  result    result_valid (one cycle)  result_row, result_value, saturated,
//                                      last
//
//  a matrix or vector load request leaves busy low
//  a compute request keeps busy high while the vector ring rotates one full lap
//  per row and the matrix ram read port supplies one element a cycle, then while
//  the drain state empties the multiply pipeline
//  results of successive rows leave a full ring lap apart; the receiver cannot stall
//  rst is synchronous and clears the sequencer, the pipeline control and the configuration registers
//  a compute with a zero size returns no result and leaves busy low
//
`default_nettype none

module matrix_vector_multiply_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // request channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic        [mvm_pkg::ACT_W-1:0]   action,
  input  wire logic        [mvm_pkg::ROW_W-1:0]   row_index,
  input  wire logic        [mvm_pkg::COL_W-1:0]   col_index,
  input  wire logic signed [mvm_pkg::DATA_W-1:0]  element_value,
  // configuration port
  input  wire logic                               cfg_write,
  input  wire logic        [mvm_pkg::CFG_A_W-1:0] cfg_index,
  input  wire logic        [mvm_pkg::CFG_W-1:0]   cfg_data,
  // result channel
  output logic                                    result_valid,
  output logic        [mvm_pkg::ROW_W-1:0]        result_row,
  output logic signed [mvm_pkg::DATA_W-1:0]       result_value,
  output logic                                    saturated,
  output logic                                    last
);

`include "matrix_vector_multiply_core_macros.svh"

  // configuration registers
  logic [mvm_pkg::CFG_W-1:0] row_count;
  logic [mvm_pkg::CFG_W-1:0] col_count;
  logic                      symmetric_mode;

  // sequencer
  mvm_pkg::state_t           state;
  mvm_pkg::state_t           state_next;
  logic [mvm_pkg::DIM_W-1:0] step;
  logic [mvm_pkg::DIM_W-1:0] step_next;
  logic [mvm_pkg::DIM_W-1:0] row;
  logic [mvm_pkg::DIM_W-1:0] row_next;
  logic [1:0]                drain;
  logic [1:0]                drain_next;
  logic [mvm_pkg::CNT_W-1:0] rows;
  logic [mvm_pkg::CNT_W-1:0] cols;
  logic                      mirror;

  // request decode
  logic                      accept;
  logic                      mat_we;
  logic                      vec_we;
  logic                      cmp_go;
  logic [mvm_pkg::CNT_W-1:0] rows_req;
  logic [mvm_pkg::CNT_W-1:0] cols_req;
  logic [mvm_pkg::ADDR_W-1:0] waddr;

  // matrix read and ring
  logic                       issue;
  logic                       swap;
  logic [mvm_pkg::ADDR_W-1:0] raddr;
  logic [mvm_pkg::DATA_W-1:0] mat_rdata;
  logic [mvm_pkg::DATA_W-1:0] ring [mvm_pkg::MAX_DIM];
  logic [mvm_pkg::DATA_W-1:0] vec_q;
  mvm_pkg::mac_tag_t          tag_issue;
  mvm_pkg::mac_tag_t          tag_q;

  assign busy   = (state != mvm_pkg::ST_IDLE);
  assign accept = start && !busy;

  // out of range indexes drop the write
  assign mat_we = accept && (action == mvm_pkg::ACT_MATRIX)
                  && (int'(row_index) < mvm_pkg::MAX_DIM)
                  && (int'(col_index) < mvm_pkg::MAX_DIM);
  assign vec_we = accept && (action == mvm_pkg::ACT_VECTOR)
                  && (int'(col_index) < mvm_pkg::MAX_DIM);
  assign waddr  = mvm_pkg::ADDR_W'(mvm_pkg::ADDR_W'(row_index)
                  * mvm_pkg::ADDR_W'(mvm_pkg::MAX_DIM) + mvm_pkg::ADDR_W'(col_index));

  // sizes clamp to the store dimension; symmetric mode is square
  assign rows_req = (int'(row_count) > mvm_pkg::MAX_DIM) ? mvm_pkg::CNT_W'(mvm_pkg::MAX_DIM)
                                                          : mvm_pkg::CNT_W'(row_count);
  assign cols_req = symmetric_mode ? rows_req
                  : (int'(col_count) > mvm_pkg::MAX_DIM) ? mvm_pkg::CNT_W'(mvm_pkg::MAX_DIM)
                                                          : mvm_pkg::CNT_W'(col_count);
  assign cmp_go   = accept && (action == mvm_pkg::ACT_COMPUTE)
                    && (rows_req != '0) && (cols_req != '0);

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count      <= '0;
      col_count      <= '0;
      symmetric_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mvm_pkg::REG_ROW_COUNT: row_count      <= cfg_data;
        mvm_pkg::REG_COL_COUNT: col_count      <= cfg_data;
        mvm_pkg::REG_SYMMETRIC: symmetric_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register and sizes latched at the compute request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvm_pkg::ST_IDLE;
      step  <= '0;
      row   <= '0;
      drain <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      row   <= row_next;
      drain <= drain_next;
    end
    if (cmp_go) begin
      rows   <= rows_req;
      cols   <= cols_req;
      mirror <= symmetric_mode && !rows_req[0];
    end
  end

  // each row walks a full lap of the ring so it ends back at home
  always_comb begin
    state_next = state;
    step_next  = step;
    row_next   = row;
    drain_next = drain;
    unique case (state)
      mvm_pkg::ST_IDLE: begin
        step_next  = '0;
        row_next   = '0;
        drain_next = '0;
        if (cmp_go) begin
          state_next = mvm_pkg::ST_RUN;
        end
      end
      mvm_pkg::ST_RUN: begin
        if (step == mvm_pkg::DIM_W'(mvm_pkg::MAX_DIM - 1)) begin
          step_next = '0;
          row_next  = row + 1'b1;
          if (mvm_pkg::CNT_W'(row) == rows - 1'b1) begin
            state_next = mvm_pkg::ST_DRAIN;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      mvm_pkg::ST_DRAIN: begin
        drain_next = drain + 1'b1;
        if (drain == 2'd3) begin
          state_next = mvm_pkg::ST_IDLE;
        end
      end
      default: state_next = mvm_pkg::ST_IDLE;
    endcase
  end

  // below the diagonal the mirrored element is read in symmetric mode with an even row count
  assign issue = (state == mvm_pkg::ST_RUN);
  assign swap  = mirror && (row > step);
  assign raddr = swap
    ? mvm_pkg::ADDR_W'(mvm_pkg::ADDR_W'(step) * mvm_pkg::ADDR_W'(mvm_pkg::MAX_DIM)
                       + mvm_pkg::ADDR_W'(row))
    : mvm_pkg::ADDR_W'(mvm_pkg::ADDR_W'(row) * mvm_pkg::ADDR_W'(mvm_pkg::MAX_DIM)
                       + mvm_pkg::ADDR_W'(step));

  always_comb begin
    tag_issue.valid    = issue && (mvm_pkg::CNT_W'(step) < cols);
    tag_issue.first    = (step == '0);
    tag_issue.last_col = (mvm_pkg::CNT_W'(step) == cols - 1'b1);
    tag_issue.last_row = (mvm_pkg::CNT_W'(row) == rows - 1'b1);
    tag_issue.row      = mvm_pkg::ROW_W'(row);
  end

  mvm_ram #(
    .WIDTH (mvm_pkg::DATA_W),
    .DEPTH (mvm_pkg::MAX_DIM * mvm_pkg::MAX_DIM)
  ) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (waddr),
    .wdata (element_value),
    .raddr (raddr),
    .rdata (mat_rdata)
  );

  // vector ring: cell 0 is the head, each cell takes its upper neighbour
  for (genvar k = 0; k < mvm_pkg::MAX_DIM; k++) begin : g_ring
    mvm_cell u_cell (
      .clk        (clk),
      .load       (vec_we && (int'(col_index) == k)),
      .load_value (element_value),
      .shift      (issue),
      .shift_in   (ring[(k + 1) % mvm_pkg::MAX_DIM]),
      .value      (ring[k])
    );
  end

  // line the vector head and the tag up with the registered ram data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_issue;
    end
    vec_q <= ring[0];
  end

  mvm_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .tag_in       (tag_q),
    .mat_value    (mat_rdata),
    .vec_value    (vec_q),
    .result_valid (result_valid),
    .result_row   (result_row),
    .result_value (result_value),
    .saturated    (saturated),
    .last         (last)
  );

  // results only leave during a compute
  `MVM_ASSERT_SAME(a_result_in_compute, result_valid, busy, "result outside a compute")
  // the pipeline is empty whenever a request can be taken
  `MVM_ASSERT_NEXT(a_quiet_after_accept, start && !busy, !result_valid,
                   "result straight after an accepted request")
  // rows are a full ring lap apart
  `MVM_ASSERT_NEXT(a_row_spacing, result_valid && !last, !result_valid,
                   "results of two rows in adjacent cycles")

endmodule

`default_nettype wire
